### sv/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// shared types, codes and tables of the memory map bus decoder
// ----------------------------------------------------------------------------
package mmbd_pkg;

  typedef enum logic [1:0] {
    OP_RD_BYTE = 2'd0,
    OP_RD_WORD = 2'd1,
    OP_WR_BYTE = 2'd2,
    OP_WR_WORD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RGN_ROM,
    RGN_VRAM,
    RGN_XRAM,
    RGN_WRAM,
    RGN_ECHO,
    RGN_OAM,
    RGN_IO,
    RGN_HRAM
  } rgn_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mem_en;
    logic second;
    logic cap_lo;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_word;
    logic is_write;
  } sts_t;

  function automatic rgn_t decode(input logic [15:0] a);
    rgn_t r;
    case (a) inside
      [16'h0000:16'h7FFF]: r = RGN_ROM;
      [16'h8000:16'h9FFF]: r = RGN_VRAM;
      [16'hA000:16'hBFFF]: r = RGN_XRAM;
      [16'hC000:16'hEFFF]: r = RGN_WRAM;
      [16'hF000:16'hFDFF]: r = RGN_ECHO;
      [16'hFE00:16'hFEFF]: r = RGN_OAM;
      [16'hFF00:16'hFF7F]: r = RGN_IO;
      default:             r = RGN_HRAM;
    endcase
    return r;
  endfunction

  // power-on values of the i/o registers
  function automatic logic [7:0] io_reset_val(input logic [6:0] idx);
    logic [7:0] v;
    case (idx)
      7'h10:   v = 8'h80;
      7'h11:   v = 8'hBF;
      7'h12:   v = 8'hF3;
      7'h14:   v = 8'hBF;
      7'h16:   v = 8'h3F;
      7'h19:   v = 8'hBF;
      7'h1A:   v = 8'h7F;
      7'h1B:   v = 8'hFF;
      7'h1C:   v = 8'h9F;
      7'h1E:   v = 8'hBF;
      7'h20:   v = 8'hFF;
      7'h23:   v = 8'hBF;
      7'h24:   v = 8'h77;
      7'h25:   v = 8'hF3;
      7'h26:   v = 8'hF1;
      7'h40:   v = 8'h91;
      7'h41:   v = 8'h84;
      7'h47:   v = 8'hFC;
      7'h48:   v = 8'hFF;
      7'h49:   v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### sv/mmbd_ram.sv
// ----------------------------------------------------------------------------
// mmbd_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module mmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mmbd_ctrl.sv
// ----------------------------------------------------------------------------
// mmbd_ctrl
// sequencer for one bus access: first byte, optional second byte, result
// ----------------------------------------------------------------------------
module mmbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mmbd_pkg::sts_t sts,
  output mmbd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.mem_en = 1'b1;
        state_nxt  = sts.is_word ? ST_SECOND : ST_FINISH;
      end
      ST_SECOND: begin
        cmd.mem_en = 1'b1;
        cmd.second = 1'b1;
        cmd.cap_lo = !sts.is_write;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/mmbd_dp.sv
// ----------------------------------------------------------------------------
// mmbd_dp
// address decode, rom index reduction, byte stores and result register
// ----------------------------------------------------------------------------
module mmbd_dp #(
  parameter int ROM_BYTES = 32768
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_opcode,
  input  logic [15:0]    in_address,
  input  logic [15:0]    in_write_data,
  output logic [15:0]    out_read_data,
  input  mmbd_pkg::cmd_t cmd,
  output mmbd_pkg::sts_t sts
);

  localparam int ROM_AW = $clog2(ROM_BYTES);
  localparam int SH     = 31;
  localparam longint unsigned RECIP = ((64'd1 << SH) + ROM_BYTES - 1) / ROM_BYTES;
  localparam int RW     = $clog2(RECIP) + 1;
  localparam int PW     = 15 + RW;
  localparam int QW     = PW - SH;
  localparam logic [RW-1:0]     RECIP_C  = RW'(RECIP);
  localparam logic [15:0]       ROM_N    = 16'(ROM_BYTES);
  localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(ROM_BYTES - 1);

  mmbd_pkg::op_t op_r;
  logic [15:0]   addr_r;
  logic [15:0]   wdata_r;
  logic [QW-1:0] quot_r;
  logic [7:0]    lo_r;
  logic [15:0]   out_data_r;
  logic [127:0]  io_vld_r;
  mmbd_pkg::rgn_t prev_rgn_r;
  logic          prev_io_vld_r;
  logic [7:0]    prev_io_rst_r;

  logic [PW-1:0]     prod;
  logic [15:0]       rem16;
  logic [ROM_AW-1:0] rom_idx0, rom_idx1, acc_rom_idx;
  logic [15:0]       addr1, acc_addr;
  logic              is_write, is_word, take_a1;
  logic [7:0]        acc_wdata, rd_byte;
  mmbd_pkg::rgn_t    acc_rgn;
  logic              rd_en, wr_en;

  logic [7:0] rom_q, vram_q, xram_q, wram_q, echo_q, oam_q, io_q, hram_q;

  assign is_write = (op_r == mmbd_pkg::OP_WR_BYTE) || (op_r == mmbd_pkg::OP_WR_WORD);
  assign is_word  = (op_r == mmbd_pkg::OP_RD_WORD) || (op_r == mmbd_pkg::OP_WR_WORD);
  assign sts.is_word  = is_word;
  assign sts.is_write = is_write;

  // quotient of the rom offset by the rom size, by reciprocal
  assign prod = PW'(in_address[14:0]) * PW'(RECIP_C);

  assign rem16    = {1'b0, addr_r[14:0]} - 16'(16'(quot_r) * ROM_N);
  assign rom_idx0 = rem16[ROM_AW-1:0];
  assign rom_idx1 = (addr_r == 16'hFFFF || rom_idx0 == ROM_LAST) ? '0 : rom_idx0 + 1'b1;
  assign addr1    = addr_r + 16'd1;

  // word write stores the high byte first
  assign take_a1     = (op_r == mmbd_pkg::OP_WR_WORD) ? !cmd.second : cmd.second;
  assign acc_addr    = take_a1 ? addr1 : addr_r;
  assign acc_rom_idx = take_a1 ? rom_idx1 : rom_idx0;
  assign acc_wdata   = (op_r == mmbd_pkg::OP_WR_WORD && !cmd.second) ?
                       wdata_r[15:8] : wdata_r[7:0];
  assign acc_rgn     = mmbd_pkg::decode(acc_addr);
  assign rd_en       = cmd.mem_en && !is_write;
  assign wr_en       = cmd.mem_en && is_write;

  mmbd_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_ROM), .we(is_write),
    .addr(acc_rom_idx), .wdata(acc_wdata), .rdata(rom_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(8192)) u_vram (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_VRAM), .we(is_write),
    .addr(acc_addr[12:0]), .wdata(acc_wdata), .rdata(vram_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(8192)) u_xram (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_XRAM), .we(is_write),
    .addr(acc_addr[12:0]), .wdata(acc_wdata), .rdata(xram_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(8192)) u_wram (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_WRAM), .we(is_write),
    .addr(acc_addr[12:0]), .wdata(acc_wdata), .rdata(wram_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(3584)) u_echo (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_ECHO), .we(is_write),
    .addr(acc_addr[11:0]), .wdata(acc_wdata), .rdata(echo_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(256)) u_oam (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_OAM), .we(is_write),
    .addr(acc_addr[7:0]), .wdata(acc_wdata), .rdata(oam_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(128)) u_io (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_IO), .we(is_write),
    .addr(acc_addr[6:0]), .wdata(acc_wdata), .rdata(io_q));

  mmbd_ram #(.WIDTH(8), .DEPTH(128)) u_hram (
    .clk(clk), .en(cmd.mem_en && acc_rgn == mmbd_pkg::RGN_HRAM), .we(is_write),
    .addr(acc_addr[6:0]), .wdata(acc_wdata), .rdata(hram_q));

  always_comb begin
    case (prev_rgn_r)
      mmbd_pkg::RGN_ROM:  rd_byte = rom_q;
      mmbd_pkg::RGN_VRAM: rd_byte = vram_q;
      mmbd_pkg::RGN_XRAM: rd_byte = xram_q;
      mmbd_pkg::RGN_WRAM: rd_byte = wram_q;
      mmbd_pkg::RGN_ECHO: rd_byte = echo_q;
      mmbd_pkg::RGN_OAM:  rd_byte = oam_q;
      mmbd_pkg::RGN_IO:   rd_byte = prev_io_vld_r ? io_q : prev_io_rst_r;
      default:            rd_byte = hram_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_vld_r <= '0;
    end else if (wr_en && acc_rgn == mmbd_pkg::RGN_IO) begin
      io_vld_r[acc_addr[6:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= mmbd_pkg::op_t'(in_opcode);
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      quot_r  <= prod[PW-1:SH];
    end
    if (rd_en) begin
      prev_rgn_r    <= acc_rgn;
      prev_io_vld_r <= io_vld_r[acc_addr[6:0]];
      prev_io_rst_r <= mmbd_pkg::io_reset_val(acc_addr[6:0]);
    end
    if (cmd.cap_lo) begin
      lo_r <= rd_byte;
    end
    if (cmd.out_load) begin
      if (is_write) begin
        out_data_r <= '0;
      end else if (is_word) begin
        out_data_r <= {rd_byte, lo_r};
      end else begin
        out_data_r <= {8'h00, rd_byte};
      end
    end
  end

  assign out_read_data = out_data_r;

endmodule

### sv/memory_map_bus_decoder.sv
// ----------------------------------------------------------------------------
// memory_map_bus_decoder
// eight-region byte memory map serving one byte or word access per item
// ----------------------------------------------------------------------------
// One item is in flight at a time. A byte access runs the first and finish
// states, a word access also the second, since every store is a single-port
// byte ram with registered read and a word touches two bytes in turn. The
// result is registered in the finish state once the output slot is free. The
// rom index (offset modulo ROM_BYTES) uses a reciprocal-multiply quotient
// registered at accept. A new item is accepted once the result is registered,
// even if the consumer stalls it. Word writes store address+1 first.
module memory_map_bus_decoder #(
  parameter int ROM_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [15:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data
);

  mmbd_pkg::cmd_t cmd;
  mmbd_pkg::sts_t sts;

  mmbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmbd_dp #(.ROM_BYTES(ROM_BYTES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_opcode),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_read_data(out_read_data),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted item did not block the input");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  a_load_not_access: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.mem_en && !cmd.out_load)
    else $error("item loaded during a store access");

  a_second_is_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.second |-> cmd.mem_en && sts.is_word)
    else $error("second byte access on a byte item");
`endif

endmodule
